FILE: rtl/srtf_pkg.sv
// Shared constants, types and helper functions for the SRTF scheduler.
package srtf_pkg;

    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 22;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = 5;
    localparam int DATA_W    = 16;
    localparam int OUT_W     = 22;
    localparam int SUM_W     = 26;
    localparam int CMD_W     = 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 152;

    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [CNT_W-1:0]     DONE_MAX  = 5'd31;
    localparam logic [TIME_BITS-1:0] TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [31:0]          OUT_MAX32 = 32'((64'd1 << OUT_W) - 64'd1);
    localparam logic [SUM_W-1:0]     SUM_MAX   = {SUM_W{1'b1}};

    // Best candidate so far, handed from cell to cell during a scan
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] arr;
        logic [DATA_W-1:0] bur;
    } cand_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                 load;
        logic                 restart;
        logic                 dec;
        logic [IDX_W-1:0]     sel_idx;
        logic [DATA_W-1:0]    arr;
        logic [DATA_W-1:0]    bur;
        logic [CNT_W-1:0]     n;
        logic [TIME_BITS-1:0] slot;
    } cell_ctrl_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic [TIME_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        sat_out = (w > OUT_MAX32) ? OUT_W'(OUT_MAX32) : OUT_W'(w);
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                  input logic [TIME_BITS-1:0] b);
        logic [32:0] s;
        s = 33'(a) + 33'(b);
        sat_sum = (s > 33'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

FILE: rtl/srtf_cell.sv
// One process table entry; compares itself against the passing candidate.
module srtf_cell
    import srtf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_id,
    input  cell_ctrl_t       ctrl,
    input  logic             in_valid,
    input  cand_t            in_rec,
    output logic             out_valid,
    output cand_t            out_rec
);

    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] arr_reg;
    logic [DATA_W-1:0] bur_reg;
    logic              written_reg;
    logic              out_valid_reg;
    cand_t             out_rec_reg;
    cand_t             out_rec_next;
    logic              hit;
    logic              eligible;
    logic              take;

    assign hit      = (ctrl.sel_idx == cell_id);
    assign eligible = (CNT_W'(cell_id) < ctrl.n) && (rem_reg != '0)
                      && (TIME_BITS'(arr_reg) <= ctrl.slot);
    assign take     = eligible && (!in_rec.found || (rem_reg < in_rec.rem));

    always_comb
    begin
        if (take)
        begin
            out_rec_next.found = 1'b1;
            out_rec_next.idx   = cell_id;
            out_rec_next.rem   = rem_reg;
            out_rec_next.arr   = arr_reg;
            out_rec_next.bur   = bur_reg;
        end
        else
        begin
            out_rec_next = in_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            written_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
            if (ctrl.load && hit)
            begin
                written_reg <= 1'b1;
                rem_reg     <= ctrl.bur;
            end
            else if (ctrl.restart)
            begin
                rem_reg <= written_reg ? bur_reg : '0;
            end
            else if (ctrl.dec && hit)
            begin
                rem_reg <= rem_reg - DATA_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_rec_reg <= out_rec_next;
        if (ctrl.load && hit)
        begin
            arr_reg <= ctrl.arr;
            bur_reg <= ctrl.bur;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rec   = out_rec_reg;

endmodule

FILE: rtl/srtf_scheduler_core.sv
// Shortest-remaining-time-first scheduler: controller and row of table cells.
//
// Load and restart transactions produce no result. A tick transaction runs a scan
// along a row of MAX_PROCS cells, one cell per cycle, each keeping the best
// candidate so far; then the calc state computes the completion figures and the
// fin state, once the output side is free, updates the sums and loads the output
// register. The next transaction is accepted in the cycle after the result is
// registered. The process_count register is written on the cfg channel, which is
// always ready.
module srtf_scheduler_core
    import srtf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [3:0] proc_index, [19:4] arrival, [35:20] burst, [39:36] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [21:0] slot_time, [25:22] proc_id, [26] proc_done, [48:27] completion,
    // [70:49] turnaround, [92:71] waiting, [118:93] sum_waiting,
    // [144:119] sum_turnaround, [145] all_done, [151:146] zero
    output logic [M_DATA_W-1:0] m_tdata,
    // [0] busy_res
    output logic                m_tuser,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_CALC, ST_FIN} state_t;

    state_t               state_reg;
    logic                 scan_start_reg;
    logic [TIME_BITS-1:0] cur_time_reg;
    logic [CNT_W-1:0]     done_count_reg;
    logic [SUM_W-1:0]     wait_total_reg;
    logic [SUM_W-1:0]     tat_total_reg;
    logic [CNT_W-1:0]     pcount_reg;
    cand_t                best_reg;
    logic                 done_reg;
    logic [TIME_BITS-1:0] comp_reg;
    logic [TIME_BITS-1:0] tat_reg;
    logic [TIME_BITS-1:0] wait_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 s_accept;
    logic [CNT_W-1:0]     n_used;
    logic [TIME_BITS-1:0] time_next;
    logic                 done_next;
    logic [TIME_BITS-1:0] comp_next;
    logic [TIME_BITS-1:0] tat_next;
    logic [TIME_BITS-1:0] wait_next;
    logic [SUM_W-1:0]     wait_total_next;
    logic [SUM_W-1:0]     tat_total_next;
    logic [CNT_W-1:0]     done_count_next;
    logic                 out_free;
    cell_ctrl_t           ctrl;

    cand_t                chain_rec [MAX_PROCS+1];
    logic                 chain_vld [MAX_PROCS+1];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign n_used = (pcount_reg > CNT_W'(MAX_PROCS)) ? CNT_W'(MAX_PROCS) : pcount_reg;

    assign ctrl.load    = s_accept && (s_tuser == CMD_LOAD);
    assign ctrl.restart = s_accept && (s_tuser == CMD_RESTART);
    assign ctrl.dec     = (state_reg == ST_CALC) && best_reg.found;
    assign ctrl.sel_idx = (state_reg == ST_CALC) ? best_reg.idx : s_tdata[IDX_W-1:0];
    assign ctrl.arr     = s_tdata[19:4];
    assign ctrl.bur     = s_tdata[35:20];
    assign ctrl.n       = n_used;
    assign ctrl.slot    = cur_time_reg;

    assign chain_rec[0] = '0;
    assign chain_vld[0] = scan_start_reg;

    for (genvar i = 0; i < MAX_PROCS; i++)
    begin : g_cell
        srtf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (IDX_W'(i)),
            .ctrl      (ctrl),
            .in_valid  (chain_vld[i]),
            .in_rec    (chain_rec[i]),
            .out_valid (chain_vld[i+1]),
            .out_rec   (chain_rec[i+1])
        );
    end

    assign time_next = (cur_time_reg == TIME_MAX) ? cur_time_reg
                                                  : cur_time_reg + TIME_BITS'(1);
    assign done_next = best_reg.found && (best_reg.rem == DATA_W'(1));
    assign comp_next = done_next ? time_next : '0;

    always_comb
    begin
        tat_next  = '0;
        wait_next = '0;
        if (done_next)
        begin
            if (comp_next >= TIME_BITS'(best_reg.arr))
                tat_next = comp_next - TIME_BITS'(best_reg.arr);
            if (tat_next >= TIME_BITS'(best_reg.bur))
                wait_next = tat_next - TIME_BITS'(best_reg.bur);
        end
    end

    assign wait_total_next = sat_sum(wait_total_reg, wait_reg);
    assign tat_total_next  = sat_sum(tat_total_reg, tat_reg);
    assign done_count_next = (done_reg && (done_count_reg < DONE_MAX))
                             ? done_count_reg + CNT_W'(1) : done_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_start_reg <= 1'b0;
            cur_time_reg   <= '0;
            done_count_reg <= '0;
            wait_total_reg <= '0;
            tat_total_reg  <= '0;
            pcount_reg     <= CNT_W'(16);
            best_reg       <= '0;
            done_reg       <= 1'b0;
            comp_reg       <= '0;
            tat_reg        <= '0;
            wait_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= 1'b0;
        end
        else
        begin
            scan_start_reg <= s_accept && (s_tuser == CMD_TICK);
            if (cfg_valid)
                pcount_reg <= cfg_data;
            if ((state_reg == ST_FIN) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tuser == CMD_TICK)
                        begin
                            state_reg      <= ST_SCAN;
                        end
                        else if (s_tuser == CMD_RESTART)
                        begin
                            cur_time_reg   <= '0;
                            done_count_reg <= '0;
                            wait_total_reg <= '0;
                            tat_total_reg  <= '0;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (chain_vld[MAX_PROCS])
                    begin
                        best_reg  <= chain_rec[MAX_PROCS];
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    done_reg  <= done_next;
                    comp_reg  <= comp_next;
                    tat_reg   <= tat_next;
                    wait_reg  <= wait_next;
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        cur_time_reg   <= time_next;
                        done_count_reg <= done_count_next;
                        wait_total_reg <= wait_total_next;
                        tat_total_reg  <= tat_total_next;
                        m_tuser_reg    <= best_reg.found;
                        m_tdata_reg    <= {6'd0,
                                           done_count_next >= n_used,
                                           tat_total_next,
                                           wait_total_next,
                                           sat_out(wait_reg),
                                           sat_out(tat_reg),
                                           sat_out(comp_reg),
                                           done_reg,
                                           best_reg.found ? best_reg.idx : IDX_W'(0),
                                           sat_out(cur_time_reg)};
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/srtf_checker.sv
// Port-level assertions for the SRTF scheduler, bound to the top level.
module srtf_checker
    import srtf_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [CMD_W-1:0]    s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    // Load and restart transactions never produce a result
    a_no_result_for_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != CMD_TICK && !m_tvalid) |=> !m_tvalid)
        else $error("result after a non-tick transaction");

    // Idle slots carry no process figures
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[92:22] == '0))
        else $error("idle slot with nonzero process fields");

    // Completion implies a busy slot
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[26]) |-> m_tuser)
        else $error("completion reported in idle slot");

    // Completion time is the end of the slot
    a_comp_time: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[26]) |->
        ((m_tdata[48:27] == m_tdata[21:0] + 22'd1) || (m_tdata[21:0] == '1)))
        else $error("completion time does not follow slot time");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind srtf_scheduler_core srtf_checker u_srtf_checker (.*);
